FILE: rtl/itf_pkg.sv
// shared constants, types and helper functions of the integer to text formatter
package itf_pkg;

    localparam int VALUE_BITS = 64;
    localparam int MAX_CHARS  = 64;

    localparam int RADIX_MIN = 2;
    localparam int RADIX_MAX = 36;

    // division unit retires this many quotient bits per cycle
    localparam int DIV_STEP   = 8;
    localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
    localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam int ND_W  = $clog2(VALUE_BITS + 1);
    localparam int LEN_W = 7;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_RADIX = 2'd1,
        STAT_TRUNC     = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CALC,
        ST_LPAD,
        ST_SIGN,
        ST_PRE0,
        ST_PREX,
        ST_ZPAD,
        ST_PREC,
        ST_DIG,
        ST_RPAD,
        ST_ERR
    } state_t;

    // order of the text sections
    function automatic state_t next_phase(input state_t s);
        state_t n;
        unique case (s)
            ST_LPAD: n = ST_SIGN;
            ST_SIGN: n = ST_PRE0;
            ST_PRE0: n = ST_PREX;
            ST_PREX: n = ST_ZPAD;
            ST_ZPAD: n = ST_PREC;
            ST_PREC: n = ST_DIG;
            ST_DIG:  n = ST_RPAD;
            default: n = ST_IDLE;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
        logic [7:0] c;
        if (d < 6'd10)
        begin
            c = CH_ZERO + 8'(d);
        end
        else
        begin
            c = (upper ? CH_UA : CH_LA) + 8'(d) - 8'd10;
        end
        return c;
    endfunction

endpackage

FILE: rtl/integer_to_text_formatter_top.sv
// printf style integer formatter: radix conversion and character sequencer
// Takes one transaction at a time. After acceptance the magnitude is divided by the
// radix repeatedly in a shared restoring divider that retires 8 quotient bits per cycle.
// The CALC state then sizes the text, and the text leaves at one character per cycle
// while out_ready is high, apart from a pause at each switch between text sections. An
// invalid radix answers with a single error transaction. in_ready is high only between
// items; the output register lets the next item be accepted while the final character
// still waits.
module integer_to_text_formatter_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [63:0]   value,
    input  logic                 is_signed,
    input  logic [5:0]           radix,
    input  logic [5:0]           min_width,
    input  logic [5:0]           min_digits,
    input  logic                 left_justify,
    input  logic                 force_plus,
    input  logic                 space_sign,
    input  logic                 alt_prefix,
    input  logic                 zero_pad,
    input  logic                 upper_case,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_char,
    output logic                 last,
    output logic [1:0]           status
);

    localparam int VB    = itf_pkg::VALUE_BITS;
    localparam int DW    = itf_pkg::DIV_W;
    localparam int DS    = itf_pkg::DIV_STEP;
    localparam int CW    = itf_pkg::DIV_CNT_W;
    localparam int NW    = itf_pkg::ND_W;
    localparam int LW    = itf_pkg::LEN_W;

    itf_pkg::state_t state_reg, state_next;

    logic [DW-1:0]  m_reg, m_next;
    logic [5:0]     rem_reg, rem_next;
    logic [CW-1:0]  step_reg, step_next;
    logic [5:0]     dig_reg [VB];
    logic [5:0]     dig_next [VB];
    logic [NW-1:0]  nd_reg, nd_next;

    logic [5:0]     radix_reg, radix_next;
    logic [5:0]     width_reg, width_next;
    logic [5:0]     mind_reg, mind_next;
    logic           left_reg, left_next;
    logic           zpad_reg, zpad_next;
    logic           upper_reg, upper_next;
    logic           alt_reg, alt_next;
    logic           mag_nz_reg, mag_nz_next;
    logic           has_sign_reg, has_sign_next;
    logic [7:0]     sign_reg, sign_next;

    logic [1:0]     pre_reg, pre_next;
    logic [5:0]     pad_reg, pad_next;
    logic [LW-1:0]  zeros_reg, zeros_next;
    logic [LW-1:0]  count_reg, count_next;
    logic           trunc_reg, trunc_next;
    logic [LW-1:0]  cnt_reg, cnt_next;
    logic [LW-1:0]  emit_cnt_reg, emit_cnt_next;

    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_char_reg, out_char_next;
    logic           last_reg, last_next;
    itf_pkg::status_t status_reg, status_next;

    // divider chain
    logic [DS-1:0]  qbits;
    logic [5:0]     rem_new;
    logic [DW-1:0]  m_new;
    logic           quot_zero;
    logic           chunk_last;

    logic           in_fire;
    logic           radix_ok;
    logic           slot_free;
    logic           is_phase;
    logic           emit;
    logic           emit_last;
    logic [7:0]     emit_char;

    // sizing
    logic [LW-1:0]  prec_calc;
    logic [1:0]     pre_calc;
    logic [LW-1:0]  total_calc;
    logic [5:0]     pad_calc;
    logic [LW-1:0]  len_calc;

    logic [VB-1:0]  raw;
    logic [VB-1:0]  mag;
    logic           neg;

    assign in_ready  = (state_reg == itf_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign radix_ok  = (radix >= 6'(itf_pkg::RADIX_MIN)) && (radix <= 6'(itf_pkg::RADIX_MAX));
    assign slot_free = !out_valid_reg || out_ready;

    assign raw = value[VB-1:0];
    assign neg = is_signed && raw[VB-1];
    // two's complement negate also gives the most negative value exactly
    assign mag = neg ? (~raw + {{(VB-1){1'b0}}, 1'b1}) : raw;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    // restoring division of the working value by the radix, DS bits per cycle
    always_comb
    begin
        logic [6:0] t;
        logic [5:0] r;
        r     = rem_reg;
        qbits = '0;
        for (int k = 0; k < DS; k++)
        begin
            t = {r, m_reg[DW-1-k]};
            if (t >= {1'b0, radix_reg})
            begin
                t = t - {1'b0, radix_reg};
                qbits[DS-1-k] = 1'b1;
            end
            r = t[5:0];
        end
        rem_new = r;
    end

    assign m_new      = (m_reg << DS) | DW'(qbits);
    assign quot_zero  = (m_new == '0);
    assign chunk_last = (step_reg == CW'(itf_pkg::DIV_CYCLES - 1));

    // text sizing from the finished digit count
    always_comb
    begin
        logic [LW-1:0] nd_ext;
        logic [LW-1:0] mind_ext;
        logic [LW-1:0] width_ext;
        nd_ext    = LW'(nd_reg);
        mind_ext  = LW'(mind_reg);
        width_ext = LW'(width_reg);
        prec_calc = (mind_ext > nd_ext) ? mind_ext : nd_ext;
        pre_calc  = 2'd0;
        if (alt_reg && mag_nz_reg)
        begin
            if (radix_reg == 6'd8 && prec_calc == nd_ext)
            begin
                pre_calc = 2'd1;
            end
            else if (radix_reg == 6'd16)
            begin
                pre_calc = 2'd2;
            end
        end
        total_calc = LW'(has_sign_reg) + LW'(pre_calc) + prec_calc;
        pad_calc   = (width_ext > total_calc) ? 6'(width_ext - total_calc) : 6'd0;
        len_calc   = total_calc + LW'(pad_calc);
    end

    assign is_phase  = (state_reg == itf_pkg::ST_LPAD) || (state_reg == itf_pkg::ST_SIGN)
                    || (state_reg == itf_pkg::ST_PRE0) || (state_reg == itf_pkg::ST_PREX)
                    || (state_reg == itf_pkg::ST_ZPAD) || (state_reg == itf_pkg::ST_PREC)
                    || (state_reg == itf_pkg::ST_DIG)  || (state_reg == itf_pkg::ST_RPAD);
    assign emit      = is_phase && (cnt_reg != '0) && slot_free;
    assign emit_last = (emit_cnt_reg == count_reg - LW'(1));

    always_comb
    begin
        unique case (state_reg)
            itf_pkg::ST_LPAD: emit_char = itf_pkg::CH_SPACE;
            itf_pkg::ST_SIGN: emit_char = sign_reg;
            itf_pkg::ST_PRE0: emit_char = itf_pkg::CH_ZERO;
            itf_pkg::ST_PREX: emit_char = upper_reg ? itf_pkg::CH_UX : itf_pkg::CH_LX;
            itf_pkg::ST_ZPAD: emit_char = itf_pkg::CH_ZERO;
            itf_pkg::ST_PREC: emit_char = itf_pkg::CH_ZERO;
            itf_pkg::ST_DIG:  emit_char = itf_pkg::digit_char(dig_reg[0], upper_reg);
            itf_pkg::ST_RPAD: emit_char = itf_pkg::CH_SPACE;
            default:          emit_char = itf_pkg::CH_NUL;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = radix_ok ? itf_pkg::ST_DIV : itf_pkg::ST_ERR;
                end
            end
            itf_pkg::ST_DIV:
            begin
                if (chunk_last && quot_zero)
                begin
                    state_next = itf_pkg::ST_CALC;
                end
            end
            itf_pkg::ST_CALC:
            begin
                state_next = itf_pkg::ST_LPAD;
            end
            itf_pkg::ST_ERR:
            begin
                if (slot_free)
                begin
                    state_next = itf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = itf_pkg::next_phase(state_reg);
                end
                else if (emit && emit_last)
                begin
                    state_next = itf_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // datapath and output register
    always_comb
    begin
        m_next        = m_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        dig_next      = dig_reg;
        nd_next       = nd_reg;
        radix_next    = radix_reg;
        width_next    = width_reg;
        mind_next     = mind_reg;
        left_next     = left_reg;
        zpad_next     = zpad_reg;
        upper_next    = upper_reg;
        alt_next      = alt_reg;
        mag_nz_next   = mag_nz_reg;
        has_sign_next = has_sign_reg;
        sign_next     = sign_reg;
        pre_next      = pre_reg;
        pad_next      = pad_reg;
        zeros_next    = zeros_reg;
        count_next    = count_reg;
        trunc_next    = trunc_reg;
        cnt_next      = cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        out_char_next = out_char_reg;
        last_next     = last_reg;
        status_next   = status_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            itf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    m_next        = DW'(mag);
                    rem_next      = '0;
                    step_next     = '0;
                    nd_next       = '0;
                    radix_next    = radix;
                    width_next    = min_width;
                    mind_next     = min_digits;
                    left_next     = left_justify;
                    zpad_next     = zero_pad && !left_justify;
                    upper_next    = upper_case;
                    alt_next      = alt_prefix;
                    mag_nz_next   = (mag != '0);
                    has_sign_next = neg || (is_signed && (force_plus || space_sign));
                    sign_next     = neg ? itf_pkg::CH_MINUS
                                  : (force_plus ? itf_pkg::CH_PLUS : itf_pkg::CH_SPACE);
                    emit_cnt_next = '0;
                end
            end
            itf_pkg::ST_DIV:
            begin
                m_next = m_new;
                if (chunk_last)
                begin
                    // remainder is the next digit, least significant first
                    for (int i = VB - 1; i > 0; i--)
                    begin
                        dig_next[i] = dig_reg[i-1];
                    end
                    dig_next[0] = rem_new;
                    nd_next     = nd_reg + NW'(1);
                    rem_next    = '0;
                    step_next   = '0;
                end
                else
                begin
                    rem_next  = rem_new;
                    step_next = step_reg + CW'(1);
                end
            end
            itf_pkg::ST_CALC:
            begin
                pre_next   = pre_calc;
                pad_next   = pad_calc;
                zeros_next = prec_calc - LW'(nd_reg);
                count_next = (len_calc > LW'(itf_pkg::MAX_CHARS)) ? LW'(itf_pkg::MAX_CHARS)
                                                                  : len_calc;
                trunc_next = (len_calc > LW'(itf_pkg::MAX_CHARS));
                cnt_next   = (!left_reg && !zpad_reg) ? LW'(pad_calc) : '0;
            end
            itf_pkg::ST_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = itf_pkg::CH_NUL;
                    last_next      = 1'b1;
                    status_next    = itf_pkg::STAT_BAD_RADIX;
                end
            end
            default:
            begin
                if (cnt_reg == '0)
                begin
                    unique case (itf_pkg::next_phase(state_reg))
                        itf_pkg::ST_SIGN: cnt_next = LW'(has_sign_reg);
                        itf_pkg::ST_PRE0: cnt_next = LW'(pre_reg != 2'd0);
                        itf_pkg::ST_PREX: cnt_next = LW'(pre_reg == 2'd2);
                        itf_pkg::ST_ZPAD: cnt_next = zpad_reg ? LW'(pad_reg) : '0;
                        itf_pkg::ST_PREC: cnt_next = zeros_reg;
                        itf_pkg::ST_DIG:  cnt_next = LW'(nd_reg);
                        itf_pkg::ST_RPAD: cnt_next = left_reg ? LW'(pad_reg) : '0;
                        default:          cnt_next = '0;
                    endcase
                end
                else if (emit)
                begin
                    cnt_next       = cnt_reg - LW'(1);
                    emit_cnt_next  = emit_cnt_reg + LW'(1);
                    out_valid_next = 1'b1;
                    out_char_next  = emit_char;
                    last_next      = emit_last;
                    status_next    = trunc_reg ? itf_pkg::STAT_TRUNC : itf_pkg::STAT_OK;
                    if (state_reg == itf_pkg::ST_DIG)
                    begin
                        // pop the most significant digit
                        for (int i = 0; i < VB - 1; i++)
                        begin
                            dig_next[i] = dig_reg[i+1];
                        end
                        dig_next[VB-1] = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            emit_cnt_reg  <= '0;
            nd_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            nd_reg        <= nd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg        <= m_next;
        rem_reg      <= rem_next;
        dig_reg      <= dig_next;
        radix_reg    <= radix_next;
        width_reg    <= width_next;
        mind_reg     <= mind_next;
        left_reg     <= left_next;
        zpad_reg     <= zpad_next;
        upper_reg    <= upper_next;
        alt_reg      <= alt_next;
        mag_nz_reg   <= mag_nz_next;
        has_sign_reg <= has_sign_next;
        sign_reg     <= sign_next;
        pre_reg      <= pre_next;
        pad_reg      <= pad_next;
        zeros_reg    <= zeros_next;
        count_reg    <= count_next;
        trunc_reg    <= trunc_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
    end

endmodule

FILE: rtl/itf_checker.sv
// port level checks of the integer to text formatter, bound to the top level
module itf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [7:0]         out_char,
    input logic               last,
    input logic [1:0]         status
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last)
            && $stable(status))
    else $error("stalled result changed");

    // block is not ready in the cycle after it takes a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a transaction");

    // an invalid radix result stands alone
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == itf_pkg::STAT_BAD_RADIX |-> last && out_char == itf_pkg::CH_NUL)
    else $error("bad radix result malformed");

    // formatted text never carries a null character
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != itf_pkg::STAT_BAD_RADIX |-> out_char != itf_pkg::CH_NUL)
    else $error("null character in formatted text");

endmodule

bind integer_to_text_formatter_top itf_checker u_itf_checker (.*);
